// ===== rtl/path_hash_table_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the path hash table engine
// Shorthand for clocked checks on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PATH_HASH_TABLE_ENGINE_UNIT_ASSERT_SVH
`define PATH_HASH_TABLE_ENGINE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PHT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pht check failed");

// Consequent must hold in the cycle after the antecedent
`define PHT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pht check failed");

`endif

// ===== rtl/pht_pkg.sv =====
// ----------------------------------------------------------------------------
// Path hash table engine package
// Command codes, sequencer states and the packing of the stream beats.
// ----------------------------------------------------------------------------
package pht_pkg;

   // Field widths on the ports
   localparam int CMD_BITS         = 2;
   localparam int KEY_PORT_BITS    = 64;
   localparam int VALUE_PORT_BITS  = 64;
   localparam int HASH_BITS        = 32;
   localparam int ENTRY_COUNT_BITS = 10;
   localparam int CFG_BITS         = 4;

   // Request beat: key, value, hash1, hash2 from bit 0 up
   localparam int KEY_LSB       = 0;
   localparam int VALUE_LSB     = KEY_LSB + KEY_PORT_BITS;
   localparam int FHASH_LSB     = VALUE_LSB + VALUE_PORT_BITS;
   localparam int SHASH_LSB     = FHASH_LSB + HASH_BITS;
   localparam int REQ_DATA_BITS = SHASH_LSB + HASH_BITS;

   // Response beat: read_value, entry_count from bit 0 up, padded to bytes
   localparam int READ_VALUE_LSB = 0;
   localparam int ENTRY_LSB      = READ_VALUE_LSB + VALUE_PORT_BITS;
   localparam int RSP_USED_BITS  = ENTRY_LSB + ENTRY_COUNT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_USED_BITS + 7) / 8) * 8;

   // search_levels after reset
   localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd4;

   // Result status
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_F,
      ST_RD_S,
      ST_CHK_S,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/pht_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module pht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/path_hash_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Path hash table engine
// Insert, delete and query over a table of cells laid out as an inverted tree.
// ----------------------------------------------------------------------------
// The table of 2^LEVELS-1 cells sits in one RAM row per cell ({valid, key,
// value}) behind a small sequencer with a single key comparator. After reset
// a clearing pass writes every row invalid, during which no request is taken;
// csr writes are taken always. A request is then accepted, the first read is
// started, and for each level visited the first and second position are read
// back to back through the one RAM read port, the next level's first read
// issued while the second position is checked; the result is posted once
// the response register is free. At most LEVELS levels are visited, fewer
// when the search hits early. Bad commands and zero search levels go
// straight to posting the result. A finished result waits in the response
// register while the next request is accepted.
// ----------------------------------------------------------------------------
module path_hash_table_engine_unit #(
   parameter int LEVELS     = 10,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pht_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // key, value, hash1, hash2
   input  logic [pht_pkg::CMD_BITS-1:0]       req_tuser,  // command
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pht_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // read_value, entry_count
   output logic                               rsp_tuser,  // status
   // search_levels register
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pht_pkg::CFG_BITS-1:0]       csr_data
);
   import pht_pkg::*;

   localparam int CELLS     = (1 << LEVELS) - 1;
   localparam int ADDR_BITS = LEVELS;
   localparam int SUB_BITS  = LEVELS - 1;
   localparam int HALF      = 1 << (LEVELS - 2);
   localparam int LVL_BITS  = $clog2(LEVELS + 1);
   localparam int ROW_BITS  = 1 + KEY_BITS + VALUE_BITS;

   // sequencer and control
   state_type               state_ff, state_in;
   logic [ADDR_BITS-1:0]    clr_ff, clr_in;
   logic [ADDR_BITS-1:0]    occ_ff, occ_in;
   logic [CFG_BITS-1:0]     search_levels_ff, search_levels_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;

   // per-request working registers
   logic [CMD_BITS-1:0]     cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [VALUE_BITS-1:0]   value_ff, value_in;
   logic [SUB_BITS-1:0]     sub_f_ff, sub_f_in;
   logic [SUB_BITS-1:0]     sub_s_ff, sub_s_in;
   logic [ADDR_BITS-1:0]    base_ff, base_in;
   logic [LVL_BITS-1:0]     rem_ff, rem_in;
   logic                    status_ff, status_in;
   logic [VALUE_BITS-1:0]   read_value_ff, read_value_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // RAM port
   logic                    ram_wr_en;
   logic [ADDR_BITS-1:0]    ram_wr_addr;
   logic [ROW_BITS-1:0]     ram_wr_data;
   logic [ADDR_BITS-1:0]    ram_rd_addr;
   logic [ROW_BITS-1:0]     ram_rd_data;

   // helpers
   logic                    req_accept;
   logic                    req_cmd_ok;
   logic [LVL_BITS-1:0]     levels_eff;
   logic [ADDR_BITS-1:0]    addr_f, addr_s, addr_nf, base_next, hit_addr;
   logic                    row_valid;
   logic [KEY_BITS-1:0]     row_key;
   logic [VALUE_BITS-1:0]   row_value;
   logic                    hit;
   logic                    slot_free;

   pht_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign req_cmd_ok = (req_tuser == CMD_INSERT) || (req_tuser == CMD_DELETE) ||
                       (req_tuser == CMD_QUERY);

   // levels searched, saturated at the tree depth
   always_comb begin
      if (int'(search_levels_ff) > LEVELS) begin
         levels_eff = LVL_BITS'(LEVELS);
      end else begin
         levels_eff = LVL_BITS'(search_levels_ff);
      end
   end

   // cell addresses for this level and the next
   assign addr_f    = ADDR_BITS'(sub_f_ff) + base_ff;
   assign addr_s    = ADDR_BITS'(sub_s_ff) + base_ff;
   assign base_next = (base_ff >> 1) + ADDR_BITS'(1 << (LEVELS - 1));
   assign addr_nf   = ADDR_BITS'(sub_f_ff >> 1) + base_next;

   // shared compare on whichever row has just come back
   assign row_valid = ram_rd_data[ROW_BITS-1];
   assign row_key   = ram_rd_data[VALUE_BITS +: KEY_BITS];
   assign row_value = ram_rd_data[VALUE_BITS-1:0];
   assign hit       = (cmd_ff == CMD_INSERT) ? !row_valid : (row_valid && (row_key == key_ff));
   assign hit_addr  = (state_ff == ST_RD_S) ? addr_f : addr_s;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_BITS'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (!req_cmd_ok || (levels_eff == '0)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RD_F;
               end
            end
         end
         ST_RD_F: begin
            state_in = ST_RD_S;
         end
         ST_RD_S: begin
            state_in = hit ? ST_DONE : ST_CHK_S;
         end
         ST_CHK_S: begin
            if (hit || (rem_ff == LVL_BITS'(1))) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RD_S;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // datapath and RAM control
   always_comb begin
      clr_in           = clr_ff;
      occ_in           = occ_ff;
      search_levels_in = search_levels_ff;
      rsp_tvalid_in    = rsp_tvalid_ff && !rsp_tready;
      cmd_in           = cmd_ff;
      key_in           = key_ff;
      value_in         = value_ff;
      sub_f_in         = sub_f_ff;
      sub_s_in         = sub_s_ff;
      base_in          = base_ff;
      rem_in           = rem_ff;
      status_in        = status_ff;
      read_value_in    = read_value_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_data_in      = rsp_data_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = hit_addr;
      ram_wr_data      = {1'b1, key_ff, value_ff};
      ram_rd_addr      = addr_f;

      if (csr_valid && csr_ready) begin
         search_levels_in = csr_data;
      end

      unique case (state_ff) inside
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + ADDR_BITS'(1);
         end
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in        = req_tuser;
               key_in        = KEY_BITS'(req_tdata[KEY_LSB +: KEY_PORT_BITS]);
               value_in      = VALUE_BITS'(req_tdata[VALUE_LSB +: VALUE_PORT_BITS]);
               sub_f_in      = SUB_BITS'(req_tdata[FHASH_LSB +: HASH_BITS] % HALF);
               sub_s_in      = SUB_BITS'(req_tdata[SHASH_LSB +: HASH_BITS] % HALF) +
                               SUB_BITS'(HALF);
               base_in       = '0;
               rem_in        = levels_eff;
               status_in     = STATUS_FAIL;
               read_value_in = '0;
            end
         end
         ST_RD_F: begin
            ram_rd_addr = addr_f;
         end
         ST_RD_S, ST_CHK_S: begin
            // first-position row in ST_RD_S, second-position row in ST_CHK_S
            ram_rd_addr = (state_ff == ST_RD_S) ? addr_s : addr_nf;
            if (hit) begin
               status_in = STATUS_OK;
               case (cmd_ff)
                  CMD_INSERT: begin
                     ram_wr_en = 1'b1;
                     occ_in    = occ_ff + ADDR_BITS'(1);
                  end
                  CMD_DELETE: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = {1'b0, key_ff, value_ff};
                     occ_in      = occ_ff - ADDR_BITS'(1);
                  end
                  default: begin
                     read_value_in = row_value;
                  end
               endcase
            end else if ((state_ff == ST_CHK_S) && (rem_ff != LVL_BITS'(1))) begin
               // step down one level
               sub_f_in = sub_f_ff >> 1;
               sub_s_in = sub_s_ff >> 1;
               base_in  = base_next;
               rem_in   = rem_ff - LVL_BITS'(1);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = '0;
               rsp_data_in[READ_VALUE_LSB +: VALUE_PORT_BITS] = VALUE_PORT_BITS'(read_value_ff);
               rsp_data_in[ENTRY_LSB +: ENTRY_COUNT_BITS]     = ENTRY_COUNT_BITS'(occ_ff);
            end
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_ff           <= '0;
         occ_ff           <= '0;
         search_levels_ff <= CFG_RESET;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_ff           <= clr_in;
         occ_ff           <= occ_in;
         search_levels_ff <= search_levels_in;
         rsp_tvalid_ff    <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      sub_f_ff      <= sub_f_in;
      sub_s_ff      <= sub_s_in;
      base_ff       <= base_in;
      rem_ff        <= rem_in;
      status_ff     <= status_in;
      read_value_ff <= read_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== rtl/pht_checker.sv =====
// ----------------------------------------------------------------------------
// Path hash table engine port checker
// Checks on the top-level ports over time, bound to every instance.
// ----------------------------------------------------------------------------
`include "path_hash_table_engine_unit_assert.svh"

module pht_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [pht_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic [pht_pkg::CMD_BITS-1:0]       req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [pht_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                               rsp_tuser,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [pht_pkg::CFG_BITS-1:0]       csr_data
);
   import pht_pkg::*;

   // a stalled response beat holds
   `PHT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // the engine works on one request at a time
   `PHT_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)

   // the clearing pass follows reset, so no request is taken straight after it
   `PHT_ASSERT_SAME(a_clear_after_reset, $past(reset), !req_tready)

   // a new result is posted only out of a busy cycle
   `PHT_ASSERT_SAME(a_rsp_from_busy, $rose(rsp_tvalid), $past(!req_tready))

   // a failed request never carries a value
   `PHT_ASSERT_SAME(a_fail_no_value, rsp_tvalid && (rsp_tuser == STATUS_FAIL), rsp_tdata[READ_VALUE_LSB +: VALUE_PORT_BITS] == '0)

endmodule

bind path_hash_table_engine_unit pht_checker u_pht_checker (.*);
